// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/rmsmm_pkg.sv -----
// Package: constants, opcodes and sequencer states of the running statistics block.
package rmsmm_pkg;

   localparam int DEFAULT_SAMPLE_BITS = 20;
   localparam int DEFAULT_COUNT_BITS  = 16;
   localparam int M2_BITS             = 64;
   localparam int ROOT_BITS           = M2_BITS / 2;
   localparam int FRAC_SHIFT          = 8;

   localparam logic OP_CLEAR = 1'b0;
   localparam logic OP_ADD   = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_DIV_MEAN,
      ST_MEAN,
      ST_MUL,
      ST_ACC,
      ST_DIV_VAR,
      ST_SQRT,
      ST_RESP
   } state_type;

endpackage

// ----- sv/running_mean_std_min_max.sv -----
// Running count, mean, standard deviation, minimum and maximum of a sample stream.
//
// Request channel req_*: tuser is the opcode (clear or add), tdata the signed Q.8 sample.
// Response channel rsp_*: one response per request, carrying count, Q.16 mean, Q.16
// population std deviation, minimum, maximum, and in tuser the dropped-sample flag.
// The block handles one request at a time; req_tready is high only while it is idle.
// A clear or a first sample goes straight from idle to the response. A regular sample
// runs a restoring divider for the mean update, a shift-add multiplier for the M2
// term, the same divider again for M2/count, then a two-bits-per-step square root.
// A dropped sample with count of two or more runs the divider and root only. The
// response is held in registers until rsp_tready; a stalled receiver holds the block,
// and no new request is taken until the response has been taken. Reset (synchronous)
// zeroes count, mean, M2, minimum and maximum and returns the sequencer to idle.
`include "assert_macros.svh"

module running_mean_std_min_max #(
   parameter int SAMPLE_BITS = rmsmm_pkg::DEFAULT_SAMPLE_BITS,
   parameter int COUNT_BITS  = rmsmm_pkg::DEFAULT_COUNT_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // [SAMPLE_BITS-1:0] sample, rest zero
   input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // [0] opcode
   input  logic [0:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // count, mean, std_dev, minimum, maximum from bit 0 up, rest zero
   output logic [((COUNT_BITS + 4 * SAMPLE_BITS + 15 + 7) / 8) * 8 - 1:0] rsp_tdata,
   // [0] ignored
   output logic [0:0] rsp_tuser
);
   import rmsmm_pkg::*;

   localparam int MEAN_BITS  = SAMPLE_BITS + FRAC_SHIFT;
   localparam int STD_BITS   = SAMPLE_BITS + 7;
   localparam int DIFF_BITS  = MEAN_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int WIDE_BITS  = (PROD_BITS > M2_BITS) ? PROD_BITS : M2_BITS;
   localparam int ACC_BITS   = WIDE_BITS + 1;
   localparam int CMP_BITS   = (ROOT_BITS > STD_BITS) ? ROOT_BITS : STD_BITS;
   localparam int REM_BITS   = ROOT_BITS + 2;
   localparam int STEP_BITS  = $clog2(M2_BITS + 1);
   localparam int RSP_FIELDS = COUNT_BITS + MEAN_BITS + STD_BITS + 2 * SAMPLE_BITS;
   localparam int RSP_BITS   = ((RSP_FIELDS + 7) / 8) * 8;

   state_type state_ff, state_in;

   logic        [COUNT_BITS-1:0]  count_ff, count_in;
   logic signed [MEAN_BITS-1:0]   mean_ff, mean_in;
   logic        [M2_BITS-1:0]     m2_ff, m2_in;
   logic signed [SAMPLE_BITS-1:0] min_ff, min_in;
   logic signed [SAMPLE_BITS-1:0] max_ff, max_in;
   logic        [STD_BITS-1:0]    std_ff, std_in;
   logic                          ignored_ff, ignored_in;

   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic                          d_neg_ff, d_neg_in;
   logic        [DIFF_BITS-1:0]   d_mag_ff, d_mag_in;
   logic        [STEP_BITS-1:0]   step_ff, step_in;
   logic        [M2_BITS-1:0]     div_ff, div_in;
   logic        [COUNT_BITS-1:0]  rem_ff, rem_in;
   logic        [COUNT_BITS-1:0]  divisor_ff, divisor_in;
   logic        [DIFF_BITS-1:0]   mul_a_ff, mul_a_in;
   logic        [DIFF_BITS-1:0]   mul_b_ff, mul_b_in;
   logic        [PROD_BITS-1:0]   prod_ff, prod_in;
   logic        [REM_BITS-1:0]    sq_rem_ff, sq_rem_in;
   logic        [ROOT_BITS-1:0]   root_ff, root_in;

   logic signed [SAMPLE_BITS-1:0] req_sample;
   logic signed [MEAN_BITS-1:0]   x_scaled;
   logic signed [DIFF_BITS-1:0]   diff, quot, mean_sum, err;
   logic        [DIFF_BITS-1:0]   diff_mag, err_mag;
   logic        [MEAN_BITS-1:0]   mean_next;
   logic        [COUNT_BITS:0]    div_r2, div_sub;
   logic                          div_ge;
   logic        [PROD_BITS-1:0]   mul_sum;
   logic        [ACC_BITS-1:0]    acc_sum;
   logic        [M2_BITS-1:0]     m2_next;
   logic        [REM_BITS-1:0]    sq_shift, sq_trial;
   logic                          sq_ge;
   logic        [ROOT_BITS-1:0]   root_next;
   logic        [STD_BITS-1:0]    std_next;
   logic                          step_last, drop;

   assign req_sample = req_tdata[SAMPLE_BITS-1:0];
   assign x_scaled   = {x_ff, {FRAC_SHIFT{1'b0}}};
   assign step_last  = (step_ff == STEP_BITS'(1));
   assign drop       = (&count_ff) || (&m2_ff);

   // mean update: d = X - mean, mean += trunc(d / n), e = X - mean
   assign diff      = {x_scaled[MEAN_BITS-1], x_scaled} - {mean_ff[MEAN_BITS-1], mean_ff};
   assign diff_mag  = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
   assign quot      = d_neg_ff ? -div_ff[DIFF_BITS-1:0] : div_ff[DIFF_BITS-1:0];
   assign mean_sum  = {mean_ff[MEAN_BITS-1], mean_ff} + quot;
   assign mean_next = mean_sum[MEAN_BITS-1:0];
   assign err       = {x_scaled[MEAN_BITS-1], x_scaled} - {mean_next[MEAN_BITS-1], mean_next};
   assign err_mag   = err[DIFF_BITS-1] ? DIFF_BITS'(-err) : DIFF_BITS'(err);

   // restoring divider step: dividend shifts out the top, quotient in at the bottom
   assign div_r2  = {rem_ff, div_ff[M2_BITS-1]};
   assign div_sub = div_r2 - {1'b0, divisor_ff};
   assign div_ge  = (div_r2 >= {1'b0, divisor_ff});

   // shift-add multiplier step, multiplier consumed from its top bit
   assign mul_sum = {prod_ff[PROD_BITS-2:0], 1'b0}
                  + (mul_b_ff[DIFF_BITS-1] ? PROD_BITS'(mul_a_ff) : PROD_BITS'(0));

   assign acc_sum = ACC_BITS'(m2_ff) + ACC_BITS'(prod_ff);
   assign m2_next = (|acc_sum[ACC_BITS-1:M2_BITS]) ? '1 : acc_sum[M2_BITS-1:0];

   // square root step: two radicand bits in, one root bit out
   assign sq_shift  = {sq_rem_ff[REM_BITS-3:0], div_ff[M2_BITS-1:M2_BITS-2]};
   assign sq_trial  = {root_ff, 2'b01};
   assign sq_ge     = (sq_shift >= sq_trial);
   assign root_next = {root_ff[ROOT_BITS-2:0], sq_ge};
   assign std_next  = (CMP_BITS'(root_next) > CMP_BITS'({STD_BITS{1'b1}})) ?
                      '1 : STD_BITS'(root_next);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      mean_in    = mean_ff;
      m2_in      = m2_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      std_in     = std_ff;
      ignored_in = ignored_ff;
      x_in       = x_ff;
      d_neg_in   = d_neg_ff;
      d_mag_in   = d_mag_ff;
      step_in    = step_ff;
      div_in     = div_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      mul_a_in   = mul_a_ff;
      mul_b_in   = mul_b_ff;
      prod_in    = prod_ff;
      sq_rem_in  = sq_rem_ff;
      root_in    = root_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               x_in       = req_sample;
               ignored_in = 1'b0;
               std_in     = '0;
               state_in   = ST_RESP;
               if (req_tuser[0] == OP_CLEAR) begin
                  count_in = '0;
                  mean_in  = '0;
                  m2_in    = '0;
                  min_in   = '0;
                  max_in   = '0;
               end else if (drop) begin
                  ignored_in = 1'b1;
                  if (count_ff >= COUNT_BITS'(2)) begin
                     div_in     = m2_ff;
                     rem_in     = '0;
                     divisor_in = count_ff;
                     step_in    = STEP_BITS'(M2_BITS);
                     state_in   = ST_DIV_VAR;
                  end
               end else if (count_ff == '0) begin
                  count_in = COUNT_BITS'(1);
                  mean_in  = {req_sample, {FRAC_SHIFT{1'b0}}};
                  m2_in    = '0;
                  min_in   = req_sample;
                  max_in   = req_sample;
               end else begin
                  state_in = ST_DIFF;
               end
            end
         end
         ST_DIFF: begin
            d_neg_in   = diff[DIFF_BITS-1];
            d_mag_in   = diff_mag;
            div_in     = M2_BITS'(diff_mag) << (M2_BITS - DIFF_BITS);
            rem_in     = '0;
            divisor_in = count_ff + COUNT_BITS'(1);
            step_in    = STEP_BITS'(DIFF_BITS);
            state_in   = ST_DIV_MEAN;
         end
         ST_DIV_MEAN, ST_DIV_VAR: begin
            div_in  = {div_ff[M2_BITS-2:0], div_ge};
            rem_in  = div_ge ? div_sub[COUNT_BITS-1:0] : div_r2[COUNT_BITS-1:0];
            step_in = step_ff - STEP_BITS'(1);
            if (step_last) begin
               if (state_ff == ST_DIV_MEAN) begin
                  state_in = ST_MEAN;
               end else begin
                  sq_rem_in = '0;
                  root_in   = '0;
                  step_in   = STEP_BITS'(ROOT_BITS);
                  state_in  = ST_SQRT;
               end
            end
         end
         ST_MEAN: begin
            mean_in  = mean_next;
            count_in = count_ff + COUNT_BITS'(1);
            if (x_ff < min_ff) min_in = x_ff;
            if (x_ff > max_ff) max_in = x_ff;
            mul_a_in = d_mag_ff;
            mul_b_in = err_mag;
            prod_in  = '0;
            step_in  = STEP_BITS'(DIFF_BITS);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = mul_sum;
            mul_b_in = mul_b_ff << 1;
            step_in  = step_ff - STEP_BITS'(1);
            if (step_last) state_in = ST_ACC;
         end
         ST_ACC: begin
            m2_in      = m2_next;
            div_in     = m2_next;
            rem_in     = '0;
            divisor_in = count_ff;
            step_in    = STEP_BITS'(M2_BITS);
            state_in   = ST_DIV_VAR;
         end
         ST_SQRT: begin
            div_in    = div_ff << 2;
            sq_rem_in = sq_ge ? sq_shift - sq_trial : sq_shift;
            root_in   = root_next;
            step_in   = step_ff - STEP_BITS'(1);
            if (step_last) begin
               std_in   = std_next;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         mean_ff  <= '0;
         m2_ff    <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         mean_ff  <= mean_in;
         m2_ff    <= m2_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      std_ff     <= std_in;
      ignored_ff <= ignored_in;
      x_ff       <= x_in;
      d_neg_ff   <= d_neg_in;
      d_mag_ff   <= d_mag_in;
      step_ff    <= step_in;
      div_ff     <= div_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      mul_a_ff   <= mul_a_in;
      mul_b_ff   <= mul_b_in;
      prod_ff    <= prod_in;
      sq_rem_ff  <= sq_rem_in;
      root_ff    <= root_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tdata  = RSP_BITS'({max_ff, min_ff, std_ff, mean_ff, count_ff});
   assign rsp_tuser  = ignored_ff;

   `ASSERT_IMP(a_one_request, clock, reset, req_tready, !rsp_tvalid,
               "request accepted while a response is pending")
   `ASSERT_NXT(a_back_idle, clock, reset, rsp_tvalid && rsp_tready, req_tready,
               "not idle after response taken")
   `ASSERT_IMP(a_drop_cause, clock, reset, rsp_tvalid && ignored_ff,
               (&count_ff) || (&m2_ff), "sample dropped without saturation")
   `ASSERT_IMP(a_min_le_max, clock, reset, count_ff != '0, min_ff <= max_ff,
               "minimum above maximum")
   `ASSERT_IMP(a_std_small_count, clock, reset, rsp_tvalid && (count_ff < COUNT_BITS'(2)),
               std_ff == '0, "nonzero std deviation with fewer than two samples")

endmodule

// ----- tb/testbench.sv -----
// Testbench for running_mean_std_min_max: directed and random request and response traffic, checked in order.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rmsmm_pkg::*;

   localparam int SAMPLE_BITS = DEFAULT_SAMPLE_BITS;
   localparam int COUNT_BITS  = DEFAULT_COUNT_BITS;
   localparam int MEAN_BITS   = SAMPLE_BITS + FRAC_SHIFT;
   localparam int STD_BITS    = SAMPLE_BITS + 7;
   localparam int REQ_W       = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_W       = ((COUNT_BITS + 4 * SAMPLE_BITS + 15 + 7) / 8) * 8;
   localparam int MEAN_LSB    = COUNT_BITS;
   localparam int STD_LSB     = MEAN_LSB + MEAN_BITS;
   localparam int MIN_LSB     = STD_LSB + STD_BITS;
   localparam int MAX_LSB     = MIN_LSB + SAMPLE_BITS;
   localparam int S_LO        = -(1 << (SAMPLE_BITS - 1));
   localparam int S_HI        = (1 << (SAMPLE_BITS - 1)) - 1;
   localparam int ITEM_TARGET = 1800;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
   localparam longint unsigned COUNT_FULL = (64'd1 << COUNT_BITS) - 1;
   localparam longint unsigned STD_MAX    = (64'd1 << STD_BITS) - 1;

   typedef struct {
      logic [COUNT_BITS-1:0]         count;
      logic signed [MEAN_BITS-1:0]   mean;
      logic [STD_BITS-1:0]           std_dev;
      logic signed [SAMPLE_BITS-1:0] minimum;
      logic signed [SAMPLE_BITS-1:0] maximum;
      logic                          ignored;
   } stats_type;

   // Predicts the statistics after each accepted request and checks the responses in order.
   class stats_tracker_type;
      int unsigned     errors;
      stats_type       expected_stats[$];
      int unsigned     n_samples;
      longint          mean_q16;
      longint unsigned m2_q32;
      longint          min_q8;
      longint          max_q8;

      function new();
         errors = 0;
         clear_stats();
      endfunction

      function void clear_stats();
         n_samples = 0;
         mean_q16  = 0;
         m2_q32    = 0;
         min_q8    = 0;
         max_q8    = 0;
      endfunction

      function bit m2_full();
         return m2_q32 == 64'hFFFF_FFFF_FFFF_FFFF;
      endfunction

      function int unsigned pending();
         return expected_stats.size();
      endfunction

      function longint unsigned floor_sqrt(longint unsigned v);
         longint unsigned root;
         longint unsigned trial;
         root = 0;
         for (int i = 31; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= v) root = trial;
         end
         return root;
      endfunction

      function void note_request(logic op, logic [SAMPLE_BITS-1:0] raw);
         stats_type                     want;
         logic signed [SAMPLE_BITS-1:0] xs;
         longint                        x, xq, d, e, mean_next, divisor;
         longint unsigned               a, b, root;
         logic [127:0]                  prod;
         logic [64:0]                   total;
         want.ignored = 1'b0;
         if (op == OP_CLEAR) begin
            clear_stats();
         end else if (n_samples >= COUNT_FULL || m2_full()) begin
            want.ignored = 1'b1;
         end else begin
            xs = raw;
            x  = xs;
            xq = x <<< FRAC_SHIFT;
            if (n_samples == 0) begin
               mean_q16 = xq;
               m2_q32   = 0;
               min_q8   = x;
               max_q8   = x;
            end else begin
               divisor   = n_samples + 1;
               d         = xq - mean_q16;
               mean_next = mean_q16 + d / divisor;
               e         = xq - mean_next;
               a         = (d < 0) ? -d : d;
               b         = (e < 0) ? -e : e;
               prod      = {64'd0, a} * {64'd0, b};
               total     = {1'b0, m2_q32} + {1'b0, prod[63:0]};
               // M2 clamps at all ones on either overflow
               if (prod[127:64] != 0 || total[64]) m2_q32 = 64'hFFFF_FFFF_FFFF_FFFF;
               else m2_q32 = total[63:0];
               mean_q16 = mean_next;
               if (x < min_q8) min_q8 = x;
               if (x > max_q8) max_q8 = x;
            end
            n_samples++;
         end
         root = 0;
         if (n_samples >= 2) begin
            root = floor_sqrt(m2_q32 / n_samples);
            if (root > STD_MAX) root = STD_MAX;
         end
         want.count   = n_samples[COUNT_BITS-1:0];
         want.mean    = mean_q16[MEAN_BITS-1:0];
         want.std_dev = root[STD_BITS-1:0];
         want.minimum = min_q8[SAMPLE_BITS-1:0];
         want.maximum = max_q8[SAMPLE_BITS-1:0];
         expected_stats.push_back(want);
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic [RSP_W-1:0] tdata, logic tuser);
         stats_type want;
         stats_type got;
         if (expected_stats.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         want        = expected_stats.pop_front();
         got.count   = tdata[COUNT_BITS-1:0];
         got.mean    = tdata[MEAN_LSB +: MEAN_BITS];
         got.std_dev = tdata[STD_LSB +: STD_BITS];
         got.minimum = tdata[MIN_LSB +: SAMPLE_BITS];
         got.maximum = tdata[MAX_LSB +: SAMPLE_BITS];
         got.ignored = tuser;
         compare_field("count", want.count, got.count);
         compare_field("mean", want.mean, got.mean);
         compare_field("std_dev", want.std_dev, got.std_dev);
         compare_field("minimum", want.minimum, got.minimum);
         compare_field("maximum", want.maximum, got.maximum);
         compare_field("ignored", want.ignored, got.ignored);
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;   // [SAMPLE_BITS-1:0] sample, rest zero
   logic [0:0]        req_tuser = '0;   // [0] opcode
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;        // count, mean, std_dev, minimum, maximum, rest zero
   logic [0:0]        rsp_tuser;        // [0] ignored

   stats_tracker_type tracker;
   int unsigned       sent_count = 0;
   bit                steady = 1'b0;

   running_mean_std_min_max DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stretches with no idling on either side
   initial forever begin
      steady = 1'b0;
      repeat ($urandom_range(200, 2000)) @(posedge clock);
      steady = 1'b1;
      repeat ($urandom_range(100, 800)) @(posedge clock);
   end

   function automatic int unsigned pause_len();
      int unsigned r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // called at a rising edge, returns at the edge where the request is taken
   task automatic send_request(logic op, logic [SAMPLE_BITS-1:0] sample);
      int unsigned gap = pause_len();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) begin
            req_tuser <= 1'($urandom_range(0, 1));
            req_tdata <= {{(REQ_W - SAMPLE_BITS){1'b0}},
                          SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1))};
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_W - SAMPLE_BITS){1'b0}}, sample};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   initial begin : response_sink
      int unsigned stall;
      forever begin
         @(posedge clock);
         stall = pause_len();
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(0, 5)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) tracker.check_response(rsp_tdata, rsp_tuser[0]);
         if (req_tvalid && req_tready)
            tracker.note_request(req_tuser[0], req_tdata[SAMPLE_BITS-1:0]);
      end
   end

   initial begin : stimulus
      int unsigned             style, run_len, spread, extra, guard, sat_start;
      int                      center, value;
      bit                      sat_done;
      logic [SAMPLE_BITS-1:0]  pick;
      tracker   = new();
      sat_done  = 1'b0;
      sat_start = $urandom_range(150, 500);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, first sample of either sign, repeats, clears
      send_request(OP_CLEAR, SAMPLE_MAX);
      send_request(OP_ADD, SAMPLE_MAX);
      send_request(OP_ADD, SAMPLE_MIN);
      send_request(OP_ADD, '0);
      send_request(OP_ADD, '1);
      send_request(OP_ADD, SAMPLE_BITS'(1));
      send_request(OP_CLEAR, '0);
      send_request(OP_ADD, SAMPLE_MIN);
      send_request(OP_ADD, SAMPLE_MIN);
      send_request(OP_ADD, SAMPLE_BITS'(12345));
      send_request(OP_ADD, SAMPLE_BITS'('h55555));
      send_request(OP_ADD, SAMPLE_BITS'('hAAAAA));
      send_request(OP_CLEAR, '1);
      send_request(OP_CLEAR, '0);
      send_request(OP_ADD, '1);
      send_request(OP_ADD, '1);
      send_request(OP_ADD, SAMPLE_MAX);
      send_request(OP_CLEAR, SAMPLE_MIN);

      while (sent_count < ITEM_TARGET) begin
         if (!sat_done && sent_count >= sat_start) begin
            // near-extreme samples of random sign until M2 clamps, then a few dropped ones
            sat_done = 1'b1;
            extra    = 0;
            guard    = 0;
            send_request(OP_CLEAR, '0);
            while (extra < 6 && guard < 1500) begin
               value = $urandom_range(0, 1) ? S_HI - int'($urandom_range(0, 63))
                                            : S_LO + int'($urandom_range(0, 63));
               send_request(OP_ADD, value[SAMPLE_BITS-1:0]);
               if (tracker.m2_full()) extra++;
               guard++;
            end
         end else begin
            style   = $urandom_range(0, 3);
            center  = int'($urandom_range(0, (1 << SAMPLE_BITS) - 1)) + S_LO;
            spread  = ($urandom_range(0, 3) == 0) ? 0 : (1 << $urandom_range(0, 12));
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                  : $urandom_range(4, 40);
            if ($urandom_range(0, 99) < 85)
               send_request(OP_CLEAR, SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1)));
            for (int k = 0; k < run_len; k++) begin
               if ($urandom_range(0, 99) < 4) begin
                  send_request(OP_CLEAR, SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1)));
               end else begin
                  case (style)
                     0: value = int'($urandom_range(0, (1 << SAMPLE_BITS) - 1)) + S_LO;
                     1: value = center + int'($urandom_range(0, 2 * spread)) - int'(spread);
                     2: value = $urandom_range(0, 1) ? S_HI - int'($urandom_range(0, 3))
                                                     : S_LO + int'($urandom_range(0, 3));
                     default: value = center;
                  endcase
                  if (value > S_HI) value = S_HI;
                  if (value < S_LO) value = S_LO;
                  pick = value[SAMPLE_BITS-1:0];
                  send_request(OP_ADD, pick);
               end
            end
         end
      end

      req_tvalid <= 1'b0;
      // let the monitor note the last request before waiting on the queue
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("** running_mean_std_min_max: PASSED **");
      else
         $display("** running_mean_std_min_max: FAILED **");
      $finish;
   end

   initial begin : watchdog
      #30_000_000;
      $display("** running_mean_std_min_max: FAILED **");
      $finish;
   end

endmodule
